/* sv/mcvw_pkg.sv */
package mcvw_pkg;

    localparam logic [2:0] ST_ACCEPTED    = 3'd0;
    localparam logic [2:0] ST_CALIBRATING = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE    = 3'd2;
    localparam logic [2:0] ST_SHORT       = 3'd3;
    localparam logic [2:0] ST_BAD_DRIVE   = 3'd4;
    localparam logic [2:0] ST_NON_FINITE  = 3'd5;
    localparam logic [2:0] ST_TICK        = 3'd6;

    localparam logic [1:0] CM_DISABLED    = 2'd0;
    localparam logic [1:0] CM_RUNNING     = 2'd1;
    localparam logic [1:0] CM_CALIBRATING = 2'd2;
    localparam logic [1:0] CM_FAULT       = 2'd3;

    localparam logic [3:0]  MIN_PAYLOAD   = 4'd7;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [31:0] F32_ONE       = 32'h3F80_0000;
    localparam logic [31:0] F32_EXP       = 32'h7F80_0000;

    // Classified item passed from front to back.
    typedef struct packed {
        logic [2:0]  status;
        logic        brake;
        logic [19:0] freq_hz;
        logic [31:0] duty_bits;
        logic        calibrating;
        logic        faulted;
        logic        bridge_running;
    } op_t;

endpackage

/* sv/mcvw_front.sv */
module mcvw_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             mode,
    input  logic             remote_frame,
    input  logic             fd_frame,
    input  logic [3:0]       payload_len,
    input  logic [7:0]       drive_byte,
    input  logic [15:0]      freq_code,
    input  logic [31:0]      duty_bits,
    input  logic             calibrating,
    input  logic             faulted,
    input  logic             bridge_running,
    output logic             op_valid,
    input  logic             op_ready,
    output mcvw_pkg::op_t    op
);

    logic          full_reg;
    mcvw_pkg::op_t op_reg;
    mcvw_pkg::op_t op_next;
    logic [31:0]   clamped;

    assign in_ready = !full_reg || op_ready;
    assign op_valid = full_reg;
    assign op       = op_reg;

    always_comb
    begin
        if ({1'b0, duty_bits[30:0]} > mcvw_pkg::F32_ONE)
            clamped = {duty_bits[31], mcvw_pkg::F32_ONE[30:0]};
        else
            clamped = duty_bits;
        if (drive_byte == 8'd1)
            clamped[31] = 1'b0;
    end

    always_comb
    begin
        op_next.brake          = drive_byte[0];
        op_next.freq_hz        = {freq_code, 3'b000} + {3'b000, freq_code, 1'b0};
        op_next.duty_bits      = clamped;
        op_next.calibrating    = calibrating;
        op_next.faulted        = faulted;
        op_next.bridge_running = bridge_running;
        if (mode)
            op_next.status = mcvw_pkg::ST_TICK;
        else if (calibrating)
            op_next.status = mcvw_pkg::ST_CALIBRATING;
        else if (remote_frame || fd_frame)
            op_next.status = mcvw_pkg::ST_BAD_TYPE;
        else if (payload_len < mcvw_pkg::MIN_PAYLOAD)
            op_next.status = mcvw_pkg::ST_SHORT;
        else if (drive_byte > 8'd1)
            op_next.status = mcvw_pkg::ST_BAD_DRIVE;
        else if ((duty_bits & mcvw_pkg::F32_EXP) == mcvw_pkg::F32_EXP)
            op_next.status = mcvw_pkg::ST_NON_FINITE;
        else
            op_next.status = mcvw_pkg::ST_ACCEPTED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (in_ready)
            full_reg <= in_valid;
    end

    // Load the queue stage on every accepted beat.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            op_reg <= op_next;
    end

endmodule

/* sv/mcvw_back.sv */
module mcvw_back
#(
    parameter int AGE_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata,
    input  logic             op_valid,
    output logic             op_ready,
    input  mcvw_pkg::op_t    op,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       status,
    output logic             request_brake,
    output logic [19:0]      request_freq_hz,
    output logic [31:0]      request_duty_bits,
    output logic [1:0]       drive_state,
    output logic             alive,
    output logic             force_disable,
    output logic [15:0]      command_age
);

    localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};
    localparam int CW = (AGE_WIDTH > 16) ? AGE_WIDTH : 16;

    logic [15:0]          timeout_reg;
    logic [AGE_WIDTH-1:0] age_reg;
    logic [AGE_WIDTH-1:0] age_next;
    logic [CW-1:0]        age_wide;
    logic                 brake_reg;
    logic [19:0]          freq_reg;
    logic [31:0]          duty_reg;
    logic                 ovalid_reg;
    logic [2:0]           status_reg;
    logic [1:0]           cmode_reg;
    logic                 alive_reg;
    logic                 fdis_reg;
    logic [15:0]          cage_reg;
    logic                 take;
    logic                 accept;
    logic                 wd_on;
    logic                 alive_next;
    logic [1:0]           cmode_next;

    assign op_ready = !ovalid_reg || out_ready;
    assign take     = op_valid && op_ready;
    assign accept   = op.status == mcvw_pkg::ST_ACCEPTED;

    always_comb
    begin
        age_next = age_reg;
        if (op.status == mcvw_pkg::ST_TICK)
        begin
            if (age_reg != AGE_MAX)
                age_next = age_reg + 1'b1;
        end
        else if (accept)
            age_next = '0;
        age_wide   = CW'(age_next);
        wd_on      = timeout_reg != 16'd0;
        alive_next = !wd_on || (age_wide < CW'(timeout_reg));
        if (op.calibrating)
            cmode_next = mcvw_pkg::CM_CALIBRATING;
        else if (op.faulted)
            cmode_next = mcvw_pkg::CM_FAULT;
        else if (!alive_next)
            cmode_next = mcvw_pkg::CM_DISABLED;
        else
            cmode_next = mcvw_pkg::CM_RUNNING;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= mcvw_pkg::TIMEOUT_RESET;
            age_reg     <= '0;
            brake_reg   <= 1'b0;
            freq_reg    <= '0;
            duty_reg    <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                timeout_reg <= cfg_wdata;
            if (op_ready)
                ovalid_reg <= op_valid;
            if (take)
            begin
                age_reg <= age_next;
                if (accept)
                begin
                    brake_reg <= op.brake;
                    freq_reg  <= op.freq_hz;
                    duty_reg  <= op.duty_bits;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg <= op.status;
            cmode_reg  <= cmode_next;
            alive_reg  <= alive_next;
            fdis_reg   <= wd_on && !alive_next && op.bridge_running;
            if (age_wide > CW'(16'hFFFF))
                cage_reg <= 16'hFFFF;
            else
                cage_reg <= age_wide[15:0];
        end
    end

    // Held request shows the last accepted command; the other outputs show the last delivered beat.
    assign out_valid         = ovalid_reg;
    assign status            = status_reg;
    assign request_brake     = brake_reg;
    assign request_freq_hz   = freq_reg;
    assign request_duty_bits = duty_reg;
    assign drive_state       = cmode_reg;
    assign alive             = alive_reg;
    assign force_disable     = fdis_reg;
    assign command_age       = cage_reg;

endmodule

/* sv/motor_command_validator_watchdog_unit.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | mode .. bridge_running
// out     | output    | out_valid / out_ready | status .. command_age
// cfg     | input     | cfg_we (no wait)      | cfg_wdata (command_timeout)
//
// One beat per cycle sustained while out_ready stays high: the front register
// classifies a beat, the back register applies it to the watchdog state.
// Each stage loads whenever its downstream slot is empty or being drained.
// Reset (rst_n, async) clears the age, the held request and sets timeout 100.
// A stalled out side fills both stages, then in_ready drops.
module motor_command_validator_watchdog_unit
#(
    parameter int AGE_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic        remote_frame,
    input  logic        fd_frame,
    input  logic [3:0]  payload_len,
    input  logic [7:0]  drive_byte,
    input  logic [15:0] freq_code,
    input  logic [31:0] duty_bits,
    input  logic        calibrating,
    input  logic        faulted,
    input  logic        bridge_running,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        request_brake,
    output logic [19:0] request_freq_hz,
    output logic [31:0] request_duty_bits,
    output logic [1:0]  drive_state,
    output logic        alive,
    output logic        force_disable,
    output logic [15:0] command_age
);

    logic          op_valid;
    logic          op_ready;
    mcvw_pkg::op_t op;

    // Classify each beat and hold it in the front queue slot.
    mcvw_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .remote_frame   (remote_frame),
        .fd_frame       (fd_frame),
        .payload_len    (payload_len),
        .drive_byte     (drive_byte),
        .freq_code      (freq_code),
        .duty_bits      (duty_bits),
        .calibrating    (calibrating),
        .faulted        (faulted),
        .bridge_running (bridge_running),
        .op_valid       (op_valid),
        .op_ready       (op_ready),
        .op             (op)
    );

    // Advance the watchdog, update the held request, register the result.
    mcvw_back #(.AGE_WIDTH(AGE_WIDTH)) u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .op_valid          (op_valid),
        .op_ready          (op_ready),
        .op                (op),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .request_brake     (request_brake),
        .request_freq_hz   (request_freq_hz),
        .request_duty_bits (request_duty_bits),
        .drive_state       (drive_state),
        .alive             (alive),
        .force_disable     (force_disable),
        .command_age       (command_age)
    );

endmodule

/* sv/mcvw_checker.sv */
module mcvw_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [1:0]  drive_state,
    input logic        alive,
    input logic        force_disable,
    input logic [31:0] request_duty_bits
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("beat dropped while stalled");

    a_fdis_alive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && force_disable |-> !alive)
        else $error("force_disable while alive");

    a_mode_alive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_state == mcvw_pkg::CM_RUNNING |-> alive)
        else $error("running while expired");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, request_duty_bits[30:0]} <= mcvw_pkg::F32_ONE)
        else $error("held duty outside unit range");

endmodule

bind motor_command_validator_watchdog_unit mcvw_checker u_mcvw_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .drive_state       (drive_state),
    .alive             (alive),
    .force_disable     (force_disable),
    .request_duty_bits (request_duty_bits)
);
